[rtl/ptt_pkg.sv]
// Package for the periodic timer table: field widths, item kind codes,
// cell operation codes and the structs shared by the cells and the sequencer.
// No dependencies.
`default_nettype none

package ptt_pkg;

  localparam int unsigned KIND_W = 2;
  localparam int unsigned ID_W = 32;
  localparam int unsigned PER_W = 32;

  localparam int unsigned MAX_RESULTS = 16;
  localparam int unsigned CNT_W = $clog2(MAX_RESULTS + 1);

  localparam logic [KIND_W-1:0] KIND_TICK = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SET = 2'd1;
  localparam logic [KIND_W-1:0] KIND_KILL = 2'd2;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd3;

  typedef enum logic [2:0] {
    OP_IDLE,
    OP_TICK,
    OP_ROT,
    OP_SET,
    OP_KILL,
    OP_CLEAR
  } op_e;

  typedef struct packed {
    logic             valid;
    logic [ID_W-1:0]  ident;
    logic [PER_W-1:0] period;
    logic [PER_W-1:0] remaining;
    logic             expired;
  } entry_t;

  typedef struct packed {
    op_e              op;
    logic [ID_W-1:0]  id;
    logic [PER_W-1:0] period;
  } ctl_t;

  typedef struct packed {
    logic            dup;
    logic            full;
    logic            head_exp;
    logic [ID_W-1:0] head_ident;
    logic            rest_exp;
  } stat_t;

endpackage

`default_nettype wire

[rtl/ptt_cell.sv]
// One cell of the sorted timer chain: holds one timer entry and moves it
// to or from its neighbors. Depends on ptt_pkg.
`default_nettype none

module ptt_cell (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire ptt_pkg::ctl_t   ctl_i,
  input  wire ptt_pkg::entry_t left_i,
  input  wire logic            left_after_i,
  input  wire logic            left_kill_i,
  input  wire ptt_pkg::entry_t right_i,
  output ptt_pkg::entry_t      entry_o,
  output logic                 after_o,
  output logic                 kill_o,
  output logic                 match_o
);

  ptt_pkg::entry_t entry_q, entry_d;

  assign match_o = entry_q.valid && (entry_q.ident == ctl_i.id);
  assign after_o = !(entry_q.valid && (entry_q.ident < ctl_i.id));
  assign kill_o = left_kill_i || match_o;
  assign entry_o = entry_q;

  always_comb begin
    entry_d = entry_q;
    unique case (ctl_i.op)
      ptt_pkg::OP_TICK: begin
        entry_d.expired = 1'b0;
        if (entry_q.valid) begin
          if (entry_q.remaining == 32'd1) begin
            entry_d.remaining = entry_q.period;
            entry_d.expired = 1'b1;
          end else begin
            entry_d.remaining = entry_q.remaining - 32'd1;
          end
        end
      end
      ptt_pkg::OP_ROT: begin
        entry_d = right_i;
      end
      ptt_pkg::OP_SET: begin
        if (left_after_i) begin
          entry_d = left_i;
        end else if (after_o) begin
          entry_d.valid = 1'b1;
          entry_d.ident = ctl_i.id;
          entry_d.period = ctl_i.period;
          entry_d.remaining = ctl_i.period;
          entry_d.expired = 1'b0;
        end
      end
      ptt_pkg::OP_KILL: begin
        if (kill_o) begin
          entry_d = right_i;
        end
      end
      ptt_pkg::OP_CLEAR: begin
        entry_d.valid = 1'b0;
        entry_d.expired = 1'b0;
      end
      default: begin
        entry_d = entry_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
    end else begin
      entry_q <= entry_d;
    end
  end

endmodule

`default_nettype wire

[rtl/ptt_seq.sv]
// Sequencer of the periodic timer table: takes command transfers, drives the
// cell chain and registers the expiry results. Depends on ptt_pkg.
`default_nettype none

module ptt_seq #(
  parameter int unsigned SLOTS = 16
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic [ptt_pkg::KIND_W-1:0] kind_i,
  input  wire logic [ptt_pkg::ID_W-1:0]   timer_id_i,
  input  wire logic [ptt_pkg::PER_W-1:0]  period_i,
  input  wire ptt_pkg::stat_t             stat_i,
  output ptt_pkg::ctl_t                   ctl_o,
  output logic                            strobe_o,
  output logic [ptt_pkg::ID_W-1:0]        expired_id_o,
  output logic                            last_o
);

  localparam int unsigned STEP_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_ROT = 2'd2;

  logic [1:0] state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [ptt_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic [ptt_pkg::KIND_W-1:0] kind_q;
  logic [ptt_pkg::ID_W-1:0] id_q;
  logic [ptt_pkg::PER_W-1:0] per_q;
  logic strobe_q, strobe_d;
  logic last_q, last_d;
  logic [ptt_pkg::ID_W-1:0] eid_q, eid_d;
  logic accept;

  assign busy = (state_q != S_IDLE);
  assign accept = start && !busy;

  always_comb begin
    state_d = state_q;
    step_d = step_q;
    cnt_d = cnt_q;
    ctl_o.op = ptt_pkg::OP_IDLE;
    ctl_o.id = id_q;
    ctl_o.period = per_q;
    strobe_d = 1'b0;
    last_d = 1'b0;
    eid_d = stat_i.head_ident;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_IDLE;
        unique case (kind_q)
          ptt_pkg::KIND_TICK: begin
            ctl_o.op = ptt_pkg::OP_TICK;
            state_d = S_ROT;
            step_d = '0;
            cnt_d = '0;
          end
          ptt_pkg::KIND_SET: begin
            if ((per_q != '0) && !stat_i.dup && !stat_i.full) begin
              ctl_o.op = ptt_pkg::OP_SET;
            end
          end
          ptt_pkg::KIND_KILL: begin
            ctl_o.op = ptt_pkg::OP_KILL;
          end
          ptt_pkg::KIND_CLEAR: begin
            ctl_o.op = ptt_pkg::OP_CLEAR;
          end
          default: begin
            ctl_o.op = ptt_pkg::OP_IDLE;
          end
        endcase
      end
      S_ROT: begin
        ctl_o.op = ptt_pkg::OP_ROT;
        if (stat_i.head_exp && (cnt_q < ptt_pkg::CNT_W'(ptt_pkg::MAX_RESULTS))) begin
          strobe_d = 1'b1;
          last_d = (cnt_q == ptt_pkg::CNT_W'(ptt_pkg::MAX_RESULTS - 1)) || !stat_i.rest_exp;
          cnt_d = cnt_q + ptt_pkg::CNT_W'(1);
        end
        if (step_q == STEP_W'(SLOTS - 1)) begin
          state_d = S_IDLE;
        end else begin
          step_d = step_q + STEP_W'(1);
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q <= '0;
      cnt_q <= '0;
      strobe_q <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q <= step_d;
      cnt_q <= cnt_d;
      strobe_q <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q <= kind_i;
      id_q <= timer_id_i;
      per_q <= period_i;
    end
    eid_q <= eid_d;
    last_q <= last_d;
  end

  assign strobe_o = strobe_q;
  assign expired_id_o = eid_q;
  assign last_o = last_q;

  a_strobe_from_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_q |-> $past(state_q) == S_ROT)
    else $error("result transfer outside the expiry pass");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= ptt_pkg::CNT_W'(ptt_pkg::MAX_RESULTS))
    else $error("expiry count beyond the result limit");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_q && last_q) |=> !strobe_q)
    else $error("result transfer after the last one of a tick");

  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == S_EXEC)
    else $error("accepted command not executed");

endmodule

`default_nettype wire

[rtl/periodic_timer_table_unit.sv]
// Top level of the periodic timer table: a chain of ptt_cell entries kept in
// ascending identifier order, driven by ptt_seq. Depends on ptt_pkg.
//
//   channel   signals                            transfer when
//   command   start, kind_i, timer_id_i,         start && !busy
//             period_i
//   result    strobe_o, expired_id_o, last_o      strobe_o (one cycle, no stall)
//
// A set, kill or clear keeps busy high through the S_EXEC state after its
// transfer; a tick keeps it high through S_EXEC, which counts down, and then
// S_ROT, which rotates the chain once around so that expiries leave in
// identifier order. Each result is registered and appears in the cycle after
// its rotation step, so the last one can fall just as busy drops. Reset empties
// the table at once. The result side cannot stall the block.
`default_nettype none

module periodic_timer_table_unit #(
  parameter int unsigned SLOTS = 16
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic [ptt_pkg::KIND_W-1:0] kind_i,
  input  wire logic [ptt_pkg::ID_W-1:0]   timer_id_i,
  input  wire logic [ptt_pkg::PER_W-1:0]  period_i,
  output logic                            strobe_o,
  output logic [ptt_pkg::ID_W-1:0]        expired_id_o,
  output logic                            last_o
);

  ptt_pkg::ctl_t   ctl;
  ptt_pkg::stat_t  stat;
  ptt_pkg::entry_t cells [SLOTS];
  ptt_pkg::entry_t tail_in;
  logic [SLOTS-1:0] after_v, kill_v, match_v, exp_v;

  always_comb begin
    tail_in = '0;
    if (ctl.op == ptt_pkg::OP_ROT) begin
      tail_in = cells[0];
      tail_in.expired = 1'b0;
    end
  end

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    ptt_pkg::entry_t left_e, right_e;
    logic left_after, left_kill;

    if (i == 0) begin : g_first
      assign left_e = '0;
      assign left_after = 1'b0;
      assign left_kill = 1'b0;
    end else begin : g_inner
      assign left_e = cells[i-1];
      assign left_after = after_v[i-1];
      assign left_kill = kill_v[i-1];
    end

    if (i == SLOTS - 1) begin : g_last
      assign right_e = tail_in;
    end else begin : g_mid
      assign right_e = cells[i+1];
    end

    ptt_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctl_i       (ctl),
      .left_i      (left_e),
      .left_after_i(left_after),
      .left_kill_i (left_kill),
      .right_i     (right_e),
      .entry_o     (cells[i]),
      .after_o     (after_v[i]),
      .kill_o      (kill_v[i]),
      .match_o     (match_v[i])
    );

    assign exp_v[i] = cells[i].expired;
  end

  assign stat.dup = |match_v;
  assign stat.full = cells[SLOTS-1].valid;
  assign stat.head_exp = cells[0].expired;
  assign stat.head_ident = cells[0].ident;
  assign stat.rest_exp = |(exp_v >> 1);

  ptt_seq #(
    .SLOTS(SLOTS)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .kind_i      (kind_i),
    .timer_id_i  (timer_id_i),
    .period_i    (period_i),
    .stat_i      (stat),
    .ctl_o       (ctl),
    .strobe_o    (strobe_o),
    .expired_id_o(expired_id_o),
    .last_o      (last_o)
  );

endmodule

`default_nettype wire
